// ===== design/ets_pkg.sv =====
// Engine tone synthesiser: shared types, sequencer states and fixed-point constants.
// Self-contained; imported by engine_tone_synth_unit.
package ets_pkg;

    // Field widths
    localparam int RPM_W    = 14;
    localparam int THR_W    = 8;
    localparam int STEP_W   = 21;
    localparam int SAMPLE_W = 15;
    localparam int FREQ_W   = 14;
    localparam int LOAD_W   = 9;
    localparam int SINE_W   = 15;

    // Input transaction: one sample tick
    typedef struct packed {
        logic [RPM_W-1:0] engine_rpm;
        logic [THR_W-1:0] throttle_level;
        logic             last_in_frame;
    } in_item_t;

    // Output transaction: one tone sample
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] tone_sample;
        logic                       frame_done;
    } out_item_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FREQ_MUL,
        ST_FREQ,
        ST_INC,
        ST_PHASE,
        ST_CRK_MUL,
        ST_SAW_MUL,
        ST_ANG,
        ST_ADDR,
        ST_ROM,
        ST_TERM_MUL,
        ST_ACC_LAST,
        ST_LOAD_MUL,
        ST_LOAD_ACC,
        ST_LIM_MUL,
        ST_FACTOR,
        ST_CRK_MUL2,
        ST_CRK_DIV,
        ST_OUT_MUL,
        ST_OUT
    } ets_state_t;

    // Sine term being fetched: crackle modulator or one of the tone partials
    typedef enum logic [1:0] {
        TERM_CRK,
        TERM_H2,
        TERM_H3,
        TERM_SUB
    } ets_term_t;

    // Reset value of the phase step register (2^32 / 44100)
    localparam logic [STEP_W-1:0] STEP_RESET = 21'd97392;

    // rpm*2/3 by reciprocal: floor(x * 43691 / 2^17) is exact for x < 2^17
    localparam logic [16:0] RECIP3      = 17'd43691;
    localparam int          RECIP3_SHIFT = 17;
    // throttle*4/5 by reciprocal: floor(x * 52429 / 2^16)
    localparam logic [16:0] RECIP5      = 17'd52429;
    localparam int          RECIP5_SHIFT = 16;

    // Frequency clamp in Q10.4 (30 Hz and 800 Hz)
    localparam logic [FREQ_W-1:0] FREQ_MIN = 14'd480;
    localparam logic [FREQ_W-1:0] FREQ_MAX = 14'd12800;

    // Load in Q1.8: 0.2 offset and unity cap
    localparam logic [LOAD_W-1:0] LOAD_BASE = 9'd51;
    localparam logic [LOAD_W-1:0] LOAD_MAX  = 9'd256;

    // Partial weights in Q1.15
    localparam logic [15:0] W_SAW = 16'd13107;
    localparam logic [15:0] W_H2  = 16'd8192;
    localparam logic [15:0] W_H3  = 16'd4915;
    localparam logic [15:0] W_SUB = 16'd6554;

    // Crackle: 100/(2pi) turns per turn in Q16, band limits and factor terms
    localparam logic [19:0]      CRK_TURNS    = 20'd1043037;
    localparam logic [RPM_W-1:0] CRK_RPM_LO   = 14'd6500;
    localparam logic [RPM_W-1:0] CRK_RPM_HI   = 14'd7500;
    localparam logic [13:0]      LIM_GAIN     = 14'd9830;
    localparam logic [14:0]      FACTOR_BASE  = 15'd22938;
    localparam int               FACTOR_SHIFT = 15;

    // Final scaling: x * 12000 / 2^38, clamped to +/-12000
    localparam logic [13:0] OUT_SCALE = 14'd12000;
    localparam int          OUT_SHIFT = 38;
    localparam int          OUT_LIMIT = 12000;

    // pi/2 in Q2.30 for the quarter-wave table
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

// ===== design/engine_tone_synth_unit.sv =====
// Engine tone synthesiser top level: sequencer, shared 41x22 multiplier, sine ROM.
// Depends on ets_pkg for payload structs, state codes and fixed-point constants.
// The crackle band (6500 < rpm < 7500) adds a crackle sine fetch and a scaling pass.
// A new transaction is accepted only in idle, after the sequencer's passes
// through the single shared multiplier; in_ready is low meanwhile.
// A finished sample waits in the output register while the next tick is accepted.
// Reset clears the phase to zero, loads the step register with 97392, drops any
// pending output; the sine table is constant and needs no clearing pass.
module engine_tone_synth_unit #(
    parameter int SINE_ENTRIES = 1024,
    parameter int PHASE_BITS   = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ets_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ets_pkg::out_item_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ets_pkg::STEP_W-1:0]        cfg_data
);
    import ets_pkg::*;

    localparam int QUARTER_N = SINE_ENTRIES / 4;
    localparam int IDX_W     = $clog2(QUARTER_N + 1);
    localparam int RK_W      = 30 + IDX_W;
    localparam int INC_SHIFT = 36 - PHASE_BITS;
    localparam int T_SHIFT   = 32 - PHASE_BITS;
    localparam int A_W       = 41;
    localparam int B_W       = 22;
    localparam int P_W       = A_W + B_W;
    localparam int Q_W       = P_W - OUT_SHIFT;

    localparam logic signed [P_W-1:0] BIAS_FACTOR = P_W'((64'd1 << FACTOR_SHIFT) - 64'd1);
    localparam logic signed [P_W-1:0] BIAS_OUT    = P_W'((64'd1 << OUT_SHIFT) - 64'd1);
    localparam logic signed [Q_W-1:0] RES_MAX     = Q_W'(OUT_LIMIT);
    localparam logic signed [Q_W-1:0] RES_MIN     = -RES_MAX;

    // Quarter-wave sine entry in Q0.15, evaluated at elaboration
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        x    = (HALF_PI_Q30 * 64'(k)) / 64'(QUARTER_N);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (sum + 64'sd16384) >>> 15;
        if (v > 64'sd32767)
        begin
            v = 64'sd32767;
        end
        return v[SINE_W-1:0];
    endfunction

    // Constant sine table
    logic [SINE_W-1:0] sine_rom [QUARTER_N+1];
    for (genvar g = 0; g <= QUARTER_N; g++)
    begin : g_rom
        assign sine_rom[g] = sine_entry(g);
    end

    // Registers
    ets_state_t                  state_reg, state_next;
    ets_term_t                   term_reg, term_next;
    logic [PHASE_BITS-1:0]       phase_reg, phase_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;
    in_item_t                    item_reg, item_next;
    out_item_t                   out_reg, out_next;
    logic [FREQ_W-1:0]           freq_reg, freq_next;
    logic [LOAD_W-1:0]           load_reg, load_next;
    logic [14:0]                 factor_reg, factor_next;
    logic signed [A_W-1:0]       acc_reg, acc_next;
    logic [31:0]                 ang_reg, ang_next;
    logic [31:0]                 crk_ang_reg, crk_ang_next;
    logic [IDX_W-1:0]            addr_reg, addr_next;
    logic                        neg_reg, neg_next;
    logic signed [15:0]          sine_reg, sine_next;
    logic signed [P_W-1:0]       prod_reg;

    // Shared multiplier
    logic                        mul_en;
    logic signed [A_W-1:0]       mul_a;
    logic signed [B_W-1:0]       mul_b;
    logic signed [P_W-1:0]       mul_p;

    // Datapath helpers
    logic [31:0]                 t32;
    logic signed [15:0]          saw;
    logic [FREQ_W-1:0]           freq_q;
    logic [LOAD_W-1:0]           load_q;
    logic [RK_W-1:0]             rk;
    logic [IDX_W-1:0]            k_idx;
    logic [SINE_W-1:0]           rom_val;
    logic [14:0]                 lim;
    logic signed [P_W-1:0]       div_factor;
    logic signed [P_W-1:0]       div_out;
    logic signed [Q_W-1:0]       res_q;
    logic signed [Q_W-1:0]       res_clamped;
    logic                        crackle;
    logic                        out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign mul_p = mul_a * mul_b;

    // Phase as a Q0.32 turn and the saw term in Q1.15
    assign t32 = 32'(phase_reg) << T_SHIFT;
    assign saw = {~t32[31], t32[30:16]};

    // Frequency and offset load from the reciprocal products, before clamping and capping
    assign freq_q = prod_reg[RECIP3_SHIFT +: FREQ_W];
    assign load_q = LOAD_W'(prod_reg[RECIP5_SHIFT +: THR_W]) + LOAD_BASE;

    // Quadrant offset scaled to the table step
    assign rk    = RK_W'(ang_reg[29:0]) * RK_W'(QUARTER_N);
    assign k_idx = rk[30 +: IDX_W];

    assign rom_val = sine_rom[addr_reg];

    // Crackle limiter: (32768 + s) >> 1
    assign lim = sine_reg[15:1] ^ 15'h4000;

    // Divide by powers of two with truncation toward zero
    assign div_factor = (prod_reg + (prod_reg[P_W-1] ? BIAS_FACTOR : '0)) >>> FACTOR_SHIFT;
    assign div_out    = (prod_reg + (prod_reg[P_W-1] ? BIAS_OUT : '0)) >>> OUT_SHIFT;
    assign res_q      = div_out[Q_W-1:0];

    always_comb
    begin
        if (res_q > RES_MAX)
        begin
            res_clamped = RES_MAX;
        end
        else if (res_q < RES_MIN)
        begin
            res_clamped = RES_MIN;
        end
        else
        begin
            res_clamped = res_q;
        end
    end

    assign crackle  = (item_reg.engine_rpm > CRK_RPM_LO) && (item_reg.engine_rpm < CRK_RPM_HI);
    assign out_free = !out_valid_reg || out_ready;

    // Sequencer: next state, datapath next values and multiplier operands
    always_comb
    begin
        state_next     = state_reg;
        term_next      = term_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        item_next      = item_reg;
        out_next       = out_reg;
        freq_next      = freq_reg;
        load_next      = load_reg;
        factor_next    = factor_reg;
        acc_next       = acc_reg;
        ang_next       = ang_reg;
        crk_ang_next   = crk_ang_reg;
        addr_next      = addr_reg;
        neg_next       = neg_reg;
        sine_next      = sine_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        // Take a configuration transaction
        if (cfg_valid)
        begin
            step_next = cfg_data;
        end

        // Drop the output once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = ST_FREQ_MUL;
                end
            end
            ST_FREQ_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = A_W'({item_reg.engine_rpm, 1'b0});
                mul_b      = B_W'(RECIP3);
                state_next = ST_FREQ;
            end
            ST_FREQ:
            begin
                if (freq_q < FREQ_MIN)
                begin
                    freq_next = FREQ_MIN;
                end
                else if (freq_q > FREQ_MAX)
                begin
                    freq_next = FREQ_MAX;
                end
                else
                begin
                    freq_next = freq_q;
                end
                mul_en     = 1'b1;
                mul_a      = A_W'(item_reg.throttle_level);
                mul_b      = B_W'(RECIP5);
                state_next = ST_INC;
            end
            ST_INC:
            begin
                load_next  = (load_q > LOAD_MAX) ? LOAD_MAX : load_q;
                mul_en     = 1'b1;
                mul_a      = A_W'(freq_reg);
                mul_b      = B_W'(step_reg);
                state_next = ST_PHASE;
            end
            ST_PHASE:
            begin
                // Advance the phase, wrapping modulo one turn
                phase_next = phase_reg + prod_reg[INC_SHIFT +: PHASE_BITS];
                state_next = ST_CRK_MUL;
            end
            ST_CRK_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = A_W'(t32);
                mul_b      = B_W'(CRK_TURNS);
                state_next = ST_SAW_MUL;
            end
            ST_SAW_MUL:
            begin
                crk_ang_next = prod_reg[47:16];
                acc_next     = '0;
                mul_en       = 1'b1;
                mul_a        = A_W'(saw);
                mul_b        = B_W'(W_SAW);
                term_next    = TERM_H2;
                state_next   = ST_ANG;
            end
            ST_ANG:
            begin
                // Accumulate the previous partial and pick the next angle
                if (term_reg != TERM_CRK)
                begin
                    acc_next = acc_reg + prod_reg[A_W-1:0];
                end
                case (term_reg)
                    TERM_H2:  ang_next = t32 << 1;
                    TERM_H3:  ang_next = t32 + (t32 << 1);
                    TERM_SUB: ang_next = t32 >> 1;
                    default:  ang_next = crk_ang_reg;
                endcase
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                addr_next  = ang_reg[30] ? (IDX_W'(QUARTER_N) - k_idx) : k_idx;
                neg_next   = ang_reg[31];
                state_next = ST_ROM;
            end
            ST_ROM:
            begin
                sine_next  = neg_reg ? -$signed({1'b0, rom_val}) : $signed({1'b0, rom_val});
                state_next = (term_reg == TERM_CRK) ? ST_LIM_MUL : ST_TERM_MUL;
            end
            ST_TERM_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = A_W'(sine_reg);
                case (term_reg)
                    TERM_H2:  mul_b = B_W'(W_H2);
                    TERM_H3:  mul_b = B_W'(W_H3);
                    TERM_SUB: mul_b = B_W'(W_SUB);
                    default:  mul_b = '0;
                endcase
                if (term_reg == TERM_SUB)
                begin
                    state_next = ST_ACC_LAST;
                end
                else
                begin
                    term_next  = ets_term_t'(term_reg + 2'd1);
                    state_next = ST_ANG;
                end
            end
            ST_ACC_LAST:
            begin
                acc_next   = acc_reg + prod_reg[A_W-1:0];
                state_next = ST_LOAD_MUL;
            end
            ST_LOAD_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = acc_reg;
                mul_b      = B_W'(load_reg);
                state_next = ST_LOAD_ACC;
            end
            ST_LOAD_ACC:
            begin
                acc_next = prod_reg[A_W-1:0];
                if (crackle)
                begin
                    term_next  = TERM_CRK;
                    state_next = ST_ANG;
                end
                else
                begin
                    state_next = ST_OUT_MUL;
                end
            end
            ST_LIM_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = A_W'(lim);
                mul_b      = B_W'(LIM_GAIN);
                state_next = ST_FACTOR;
            end
            ST_FACTOR:
            begin
                factor_next = FACTOR_BASE + 15'(prod_reg[FACTOR_SHIFT +: 14]);
                state_next  = ST_CRK_MUL2;
            end
            ST_CRK_MUL2:
            begin
                mul_en     = 1'b1;
                mul_a      = acc_reg;
                mul_b      = B_W'(factor_reg);
                state_next = ST_CRK_DIV;
            end
            ST_CRK_DIV:
            begin
                acc_next   = div_factor[A_W-1:0];
                state_next = ST_OUT_MUL;
            end
            ST_OUT_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = acc_reg;
                mul_b      = B_W'(OUT_SCALE);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_next.tone_sample = res_clamped[SAMPLE_W-1:0];
                    out_next.frame_done  = item_reg.last_in_frame;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg      <= TERM_CRK;
            phase_reg     <= '0;
            step_reg      <= STEP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            term_reg      <= term_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        out_reg     <= out_next;
        freq_reg    <= freq_next;
        load_reg    <= load_next;
        factor_reg  <= factor_next;
        acc_reg     <= acc_next;
        ang_reg     <= ang_next;
        crk_ang_reg <= crk_ang_next;
        addr_reg    <= addr_next;
        neg_reg     <= neg_next;
        sine_reg    <= sine_next;
        if (mul_en)
        begin
            prod_reg <= mul_p;
        end
    end

endmodule
